>>> rtl/ckt_pkg.sv
`default_nettype none
package ckt_pkg;

  localparam int unsigned CORNER_COUNT = 4;
  localparam int unsigned COORD_COUNT  = 2 * CORNER_COUNT;
  localparam int unsigned COORD_W      = 24;
  localparam int unsigned STAMP_W      = 48;
  localparam int unsigned VAR_W        = 32;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned QUOT_W       = GAIN_W + 1;
  localparam int unsigned MUL_W        = 33;
  localparam int unsigned PROD_W       = 2 * MUL_W;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned IN_DATA_W    = 240;
  localparam int unsigned OUT_DATA_W   = 200;

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_DIST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_SIGMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_SIGMA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_SIGMA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SILENT = 3'd5;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [VAR_W-1:0] VAR_ONE = 32'h0001_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    logic             start;
    logic [VAR_W-1:0] num;
    logic [VAR_W:0]   den;
  } div_req_t;

endpackage
`default_nettype wire

>>> rtl/corner_kalman_tracker.sv
`default_nettype none
// Scalar Kalman tracker for the four corners of a tag. Each input transaction
// is an observation (tuser 0) or a freshness tick (tuser 1); each gives one
// result transaction. The block takes one item at a time. A fused observation
// uses the shared 33x33 multiplier (squares, gain products, variance update,
// one corner coordinate at a time through ST_FM and ST_FW) and the bit-serial
// gain divider, which forms the 17 quotient bits in turn and then hands the
// quotient over (skipped when P'+r is zero). A finished result waits in its own
// register, so the next item is taken while it is pending; a new result cannot
// leave the block until that earlier result transaction completes, and the
// block stays busy meanwhile.
module corner_kalman_tracker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // stamp, corner0_x, corner0_y, corner1_x, ... corner3_y
  input  wire logic [ckt_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // command
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // accepted, fresh, is_converged, filt0_x, filt0_y, ... filt3_y, zero pad
  output logic [ckt_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ckt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [ckt_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ckt_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SUMS = 5'd1;
  localparam logic [4:0] ST_SX   = 5'd2;
  localparam logic [4:0] ST_SY   = 5'd3;
  localparam logic [4:0] ST_LIM  = 5'd4;
  localparam logic [4:0] ST_JUMP = 5'd5;
  localparam logic [4:0] ST_Q    = 5'd6;
  localparam logic [4:0] ST_R    = 5'd7;
  localparam logic [4:0] ST_DEN  = 5'd8;
  localparam logic [4:0] ST_DIV  = 5'd9;
  localparam logic [4:0] ST_FM   = 5'd10;
  localparam logic [4:0] ST_FW   = 5'd11;
  localparam logic [4:0] ST_VAR  = 5'd12;
  localparam logic [4:0] ST_VW   = 5'd13;
  localparam logic [4:0] ST_CSQ  = 5'd14;
  localparam logic [4:0] ST_CONV = 5'd15;

  logic [4:0] state_q;

  logic [22:0] rst_dist_q;
  logic [15:0] psig_q, msig_q, csig_q;
  logic [31:0] min_time_q, max_sil_q;

  logic               cmd_q;
  logic [STAMP_W-1:0] stamp_q;
  coord_t             z_q   [COORD_COUNT];
  coord_t             est_q [COORD_COUNT];
  logic               started_q;
  logic [STAMP_W-1:0] start_time_q, last_seen_q;
  logic [VAR_W-1:0]   var_q, pp_q;
  logic signed [26:0] sx_q, sy_q;
  logic [53:0]        acc_q;
  logic [GAIN_W-1:0]  k_q;
  logic [2:0]         idx_q;
  logic               accepted_q, fresh_q;
  logic               m_valid_q;
  logic [OUT_DATA_W-1:0] out_q;

  logic               in_fire, out_fire, out_load;
  logic signed [26:0] sx_d, sy_d;
  mul_op_t            mul_a, mul_b;
  logic               mul_en;
  prod_t              prod;
  div_req_t           div_req;
  logic               div_done;
  logic [QUOT_W-1:0]  quot;
  logic [VAR_W:0]     pp_sum;
  logic [VAR_W:0]     den;
  logic [STAMP_W-1:0] silence, age;
  logic               conv;
  logic signed [COORD_W:0] resid;
  prod_t              fuse_t;
  coord_t             fuse_x;
  logic [PROD_W-1:0]  var_t;
  logic [OUT_DATA_W-1:0] out_d;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign out_load      = (state_q == ST_CONV) && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    sx_d = '0;
    sy_d = '0;
    for (int c = 0; c < CORNER_COUNT; c++) begin
      sx_d = sx_d + 27'(est_q[2*c]) - 27'(z_q[2*c]);
      sy_d = sy_d + 27'(est_q[2*c+1]) - 27'(z_q[2*c+1]);
    end
  end

  assign resid   = 25'(z_q[idx_q]) - 25'(est_q[idx_q]);
  assign pp_sum  = {1'b0, var_q} + prod[VAR_W:0];
  assign den     = {1'b0, pp_q} + prod[VAR_W:0];
  assign fuse_t  = (prod + PROD_W'(32768)) >>> 16;
  assign fuse_x  = COORD_W'(PROD_W'(est_q[idx_q]) + fuse_t);
  assign var_t   = (prod + PROD_W'(32768)) >> 16;
  assign silence = stamp_q - last_seen_q;
  assign age     = last_seen_q - start_time_q;
  assign conv    = started_q && (age >= {16'b0, min_time_q})
                   && ({32'b0, var_q} <= prod[63:0]);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_q)
      ST_SX:   begin mul_a = MUL_W'(sx_q); mul_b = MUL_W'(sx_q); end
      ST_SY:   begin mul_a = MUL_W'(sy_q); mul_b = MUL_W'(sy_q); end
      ST_LIM:  begin
        mul_a = {8'b0, rst_dist_q, 2'b00};
        mul_b = {8'b0, rst_dist_q, 2'b00};
      end
      ST_Q:    begin mul_a = {17'b0, psig_q}; mul_b = {17'b0, psig_q}; end
      ST_R:    begin mul_a = {17'b0, msig_q}; mul_b = {17'b0, msig_q}; end
      ST_FM:   begin mul_a = MUL_W'(resid); mul_b = {17'b0, k_q}; end
      ST_VAR:  begin
        mul_a = {1'b0, pp_q};
        mul_b = {16'b0, 17'h1_0000 - {1'b0, k_q}};
      end
      ST_CSQ:  begin mul_a = {17'b0, csig_q}; mul_b = {17'b0, csig_q}; end
      default: mul_en = 1'b0;
    endcase
  end

  ckt_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_req.start = (state_q == ST_DEN) && (den != '0);
  assign div_req.num   = pp_q;
  assign div_req.den   = den;

  ckt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    out_d = '0;
    out_d[0] = accepted_q;
    out_d[1] = fresh_q;
    out_d[2] = conv;
    for (int i = 0; i < COORD_COUNT; i++) begin
      out_d[3 + COORD_W*i +: COORD_W] = started_q ? est_q[i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_dist_q <= 23'd5120;
      psig_q     <= 16'd256;
      msig_q     <= 16'd256;
      csig_q     <= 16'd128;
      min_time_q <= 32'd1000000;
      max_sil_q  <= 32'd500000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RESET_DIST: rst_dist_q <= cfg_data_i[22:0];
        CFG_PROC_SIGMA: psig_q     <= cfg_data_i[15:0];
        CFG_MEAS_SIGMA: msig_q     <= cfg_data_i[15:0];
        CFG_CONV_SIGMA: csig_q     <= cfg_data_i[15:0];
        CFG_MIN_TIME:   min_time_q <= cfg_data_i;
        CFG_MAX_SILENT: max_sil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      started_q    <= 1'b0;
      start_time_q <= '0;
      last_seen_q  <= '0;
      var_q        <= VAR_ONE;
      m_valid_q    <= 1'b0;
      idx_q        <= '0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (out_fire) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_SUMS;
          end
        end
        ST_SUMS: begin
          if (cmd_q == CMD_TICK) begin
            state_q <= ST_CSQ;
          end else begin
            last_seen_q <= stamp_q;
            if (!started_q) begin
              started_q    <= 1'b1;
              start_time_q <= stamp_q;
              var_q        <= VAR_ONE;
              state_q      <= ST_CSQ;
            end else begin
              state_q <= ST_SX;
            end
          end
        end
        ST_SX:   state_q <= ST_SY;
        ST_SY:   state_q <= ST_LIM;
        ST_LIM:  state_q <= ST_JUMP;
        ST_JUMP: begin
          if (acc_q > prod[53:0]) begin
            start_time_q <= stamp_q;
            var_q        <= VAR_ONE;
            state_q      <= ST_CSQ;
          end else begin
            state_q <= ST_Q;
          end
        end
        ST_Q:    state_q <= ST_R;
        ST_R:    state_q <= ST_DEN;
        ST_DEN: begin
          idx_q   <= '0;
          state_q <= (den == '0) ? ST_FM : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_FM;
          end
        end
        ST_FM:   state_q <= ST_FW;
        ST_FW: begin
          idx_q   <= idx_q + 3'd1;
          state_q <= (idx_q == 3'(COORD_COUNT - 1)) ? ST_VAR : ST_FM;
        end
        ST_VAR:  state_q <= ST_VW;
        ST_VW: begin
          var_q   <= var_t[VAR_W-1:0];
          state_q <= ST_CSQ;
        end
        ST_CSQ:  state_q <= ST_CONV;
        ST_CONV: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q   <= s_axis_tuser;
      stamp_q <= s_axis_tdata[STAMP_W-1:0];
      for (int i = 0; i < COORD_COUNT; i++) begin
        z_q[i] <= s_axis_tdata[STAMP_W + COORD_W*i +: COORD_W];
      end
    end
    case (state_q)
      ST_SUMS: begin
        sx_q       <= sx_d;
        sy_q       <= sy_d;
        accepted_q <= (cmd_q == CMD_OBSERVE);
        fresh_q    <= (cmd_q == CMD_OBSERVE) || (silence < {16'b0, max_sil_q});
        if ((cmd_q == CMD_OBSERVE) && !started_q) begin
          for (int i = 0; i < COORD_COUNT; i++) est_q[i] <= z_q[i];
        end
      end
      ST_SY:   acc_q <= prod[53:0];
      ST_LIM:  acc_q <= acc_q + prod[53:0];
      ST_JUMP: begin
        if (acc_q > prod[53:0]) begin
          accepted_q <= 1'b0;
          for (int i = 0; i < COORD_COUNT; i++) est_q[i] <= z_q[i];
        end
      end
      ST_R:    pp_q <= pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
      ST_DEN:  k_q  <= '0;
      ST_DIV: begin
        if (div_done) begin
          k_q <= quot[GAIN_W] ? '1 : quot[GAIN_W-1:0];
        end
      end
      ST_FW:   est_q[idx_q] <= fuse_x;
      ST_CONV: begin
        if (out_load) begin
          out_q <= out_d;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ckt_mul.sv
`default_nettype none
module ckt_mul (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire ckt_pkg::mul_op_t a_i,
  input  wire ckt_pkg::mul_op_t b_i,
  output ckt_pkg::prod_t      p_o
);
  import ckt_pkg::*;

  prod_t p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> rtl/ckt_div.sv
`default_nettype none
module ckt_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire ckt_pkg::div_req_t        req_i,
  output logic                          done_o,
  output logic [ckt_pkg::QUOT_W-1:0]    quot_o
);
  import ckt_pkg::*;

  logic [VAR_W+1:0]  rem_q;
  logic [VAR_W:0]    den_q;
  logic [QUOT_W-1:0] quot_q;
  logic [4:0]        cnt_q;
  logic              busy_q, done_q;
  logic [VAR_W+2:0]  diff;
  logic              ge;
  logic [VAR_W+1:0]  rem_n;

  // numerator is num * 2^16, so only zero bits are shifted in
  assign diff  = {1'b0, rem_q} - {2'b00, den_q};
  assign ge    = ~diff[VAR_W+2];
  assign rem_n = ge ? diff[VAR_W+1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {2'b00, req_i.num};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {rem_n[VAR_W:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

>>> rtl/ckt_checker.sv
`default_nettype none
module ckt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [ckt_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

  // one item at a time: busy right after a transaction
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after input transaction");

  // no result appears in the cycle after an input is taken
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result without processing time");

  // an accepted observation is always fresh
  a_accept_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[1])
    else $error("accepted result not fresh");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped or changed while stalled");

endmodule

bind corner_kalman_tracker ckt_checker u_ckt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

>>> tb/tb_corner_kalman_checker.sv
`timescale 1ns / 1ps
module tb_corner_kalman_checker
  import ckt_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic                    in_ready_i,
  input  wire logic [IN_DATA_W-1:0]    in_data_i,
  input  wire logic                    in_cmd_i,
  input  wire logic                    out_valid_i,
  input  wire logic                    out_ready_i,
  input  wire logic [OUT_DATA_W-1:0]   out_data_i,
  input  wire logic                    cfg_valid_i,
  input  wire logic                    cfg_ready_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           results_o,
  output int                           restarts_o,
  output int                           converged_o
);

  logic [22:0] reg_reset_dist;
  logic [15:0] reg_proc_sigma, reg_meas_sigma, reg_conv_sigma;
  logic [31:0] reg_min_time, reg_max_silent;

  logic                  tracking;
  logic [STAMP_W-1:0]    start_stamp, seen_stamp;
  logic signed [31:0]    est [COORD_COUNT];
  logic [VAR_W-1:0]      var_q16;

  logic [OUT_DATA_W-1:0] expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] blend(logic signed [31:0] x, logic signed [31:0] z,
                                               logic [16:0] k);
    logic signed [63:0] t;
    t = (64'(z) - 64'(x)) * $signed({47'd0, k}) + 64'sd32768;
    return x + 32'(t >>> 16);
  endfunction

  task automatic track_step(input logic cmd, input logic [IN_DATA_W-1:0] d,
                            output logic [OUT_DATA_W-1:0] res);
    logic [STAMP_W-1:0] stamp;
    logic signed [31:0] z [COORD_COUNT];
    logic acc, fr, conv, restart;
    logic signed [63:0] sx, sy;
    logic [63:0] d2, lim, q, r, pp, den, k;
    stamp = d[STAMP_W-1:0];
    for (int i = 0; i < COORD_COUNT; i++)
      z[i] = 32'(coord_t'(d[STAMP_W + i*COORD_W +: COORD_W]));
    acc = 1'b0;
    fr = 1'b0;
    if (cmd == CMD_TICK) begin
      fr = ((stamp - seen_stamp) & 48'hFFFF_FFFF_FFFF) < 48'(reg_max_silent);
    end else begin
      restart = !tracking;
      acc = 1'b1;
      fr = 1'b1;
      seen_stamp = stamp;
      if (tracking) begin
        sx = 0;
        sy = 0;
        for (int i = 0; i < CORNER_COUNT; i++) begin
          sx += 64'(est[2*i]) - 64'(z[2*i]);
          sy += 64'(est[2*i+1]) - 64'(z[2*i+1]);
        end
        d2 = 64'(sx * sx) + 64'(sy * sy);
        lim = 64'(reg_reset_dist) * CORNER_COUNT;
        lim = lim * lim;
        if (d2 > lim) begin
          restart = 1'b1;
          acc = 1'b0;
          restarts_o++;
        end
      end
      if (restart) begin
        tracking = 1'b1;
        start_stamp = stamp;
        for (int i = 0; i < COORD_COUNT; i++) est[i] = z[i];
        var_q16 = VAR_ONE;
      end else begin
        q = 64'(reg_proc_sigma) * reg_proc_sigma;
        r = 64'(reg_meas_sigma) * reg_meas_sigma;
        pp = 64'(var_q16) + q;
        if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
        den = pp + r;
        k = 0;
        if (den != 0) begin
          k = (pp << 16) / den;
          if (k > 65535) k = 65535;
        end
        for (int i = 0; i < COORD_COUNT; i++) est[i] = blend(est[i], z[i], 17'(k));
        var_q16 = 32'((pp * (64'd65536 - k) + 64'd32768) >> 16);
      end
    end
    conv = tracking && (((seen_stamp - start_stamp) & 48'hFFFF_FFFF_FFFF) >= 48'(reg_min_time))
           && (64'(var_q16) <= 64'(reg_conv_sigma) * reg_conv_sigma);
    if (conv) converged_o++;
    res = '0;
    res[0] = acc;
    res[1] = fr;
    res[2] = conv;
    for (int i = 0; i < COORD_COUNT; i++)
      res[3 + i*COORD_W +: COORD_W] = tracking ? est[i][COORD_W-1:0] : '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OUT_DATA_W-1:0] res, exp_res;
    if (!rst_ni) begin
      reg_reset_dist = 23'd5120;
      reg_proc_sigma = 16'd256;
      reg_meas_sigma = 16'd256;
      reg_conv_sigma = 16'd128;
      reg_min_time = 32'd1000000;
      reg_max_silent = 32'd500000;
      tracking = 1'b0;
      start_stamp = '0;
      seen_stamp = '0;
      for (int i = 0; i < COORD_COUNT; i++) est[i] = 0;
      var_q16 = VAR_ONE;
      expected_q.delete();
      errors_o = 0;
      results_o = 0;
      restarts_o = 0;
      converged_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_RESET_DIST: reg_reset_dist = cfg_data_i[22:0];
          CFG_PROC_SIGMA: reg_proc_sigma = cfg_data_i[15:0];
          CFG_MEAS_SIGMA: reg_meas_sigma = cfg_data_i[15:0];
          CFG_CONV_SIGMA: reg_conv_sigma = cfg_data_i[15:0];
          CFG_MIN_TIME:   reg_min_time = cfg_data_i;
          CFG_MAX_SILENT: reg_max_silent = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result transaction, actual %h", $time, out_data_i);
        end else begin
          exp_res = expected_q.pop_front();
          for (int f = 0; f < 3 + COORD_COUNT; f++) begin
            logic [COORD_W-1:0] e, a;
            e = (f < 3) ? COORD_W'(exp_res[f]) : exp_res[3 + (f-3)*COORD_W +: COORD_W];
            a = (f < 3) ? COORD_W'(out_data_i[f]) : out_data_i[3 + (f-3)*COORD_W +: COORD_W];
            if (e !== a) begin
              errors_o++;
              $display("%0t: field %0d mismatch, expected %h, actual %h", $time, f, e, a);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        track_step(in_cmd_i, in_data_i, res);
        expected_q = {expected_q, res};
      end
    end
  end

endmodule

>>> tb/tb_corner_kalman_tracker.sv
`timescale 1ns / 1ps
module tb_corner_kalman_tracker;
  import ckt_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = CMD_OBSERVE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_RESET_DIST;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int errors, pending, results, restarts, converged;
  bit calm;
  logic [STAMP_W-1:0] clock_us;
  coord_t base [COORD_COUNT];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  corner_kalman_tracker uut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  tb_corner_kalman_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_cmd_i(s_axis_tuser),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .restarts_o(restarts), .converged_o(converged)
  );

  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 11);

  task automatic send_item(input logic cmd, input logic [STAMP_W-1:0] stamp,
                           input coord_t c [COORD_COUNT]);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[STAMP_W-1:0] = stamp;
    for (int i = 0; i < COORD_COUNT; i++) d[STAMP_W + i*COORD_W +: COORD_W] = c[i];
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all(input logic [31:0] rd, ps, ms, cs, mt, mx);
    write_reg(CFG_RESET_DIST, rd);
    write_reg(CFG_PROC_SIGMA, ps);
    write_reg(CFG_MEAS_SIGMA, ms);
    write_reg(CFG_CONV_SIGMA, cs);
    write_reg(CFG_MIN_TIME, mt);
    write_reg(CFG_MAX_SILENT, mx);
  endtask

  task automatic send_rand_item(input int jitter, input bit wild);
    coord_t c [COORD_COUNT];
    logic cmd;
    cmd = ($urandom_range(99) < 25) ? CMD_TICK : CMD_OBSERVE;
    clock_us += STAMP_W'($urandom_range(60000, 0));
    if ($urandom_range(99) < 3) clock_us = STAMP_W'({$urandom, $urandom});
    if ($urandom_range(99) < 4)
      for (int i = 0; i < COORD_COUNT; i++) base[i] = coord_t'($urandom_range(200000) - 100000);
    for (int i = 0; i < COORD_COUNT; i++)
      c[i] = wild ? coord_t'($urandom) : base[i] + coord_t'($urandom_range(2*jitter) - jitter);
    send_item(cmd, clock_us, c);
  endtask

  initial begin
    #2000000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    coord_t c [COORD_COUNT];
    calm = 1'b0;
    clock_us = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // tick before any track, then extremes
    for (int i = 0; i < COORD_COUNT; i++) c[i] = '0;
    send_item(CMD_TICK, 48'd0, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = 24'sh7FFFFF;
    send_item(CMD_OBSERVE, 48'hFFFF_FFFF_FFFF, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = -24'sh800000;
    send_item(CMD_OBSERVE, 48'd5, c);
    send_item(CMD_OBSERVE, 48'd10, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = -24'sh7FFF00;
    send_item(CMD_OBSERVE, 48'd20, c);
    send_item(CMD_TICK, 48'd3, c);
    send_item(CMD_TICK, 48'h8000_0000_0000, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = coord_t'(i * 1000);
    send_item(CMD_OBSERVE, 48'd2000000, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = coord_t'(i * 1000 + 300);
    send_item(CMD_OBSERVE, 48'd3100000, c);
    drain();

    set_all(32'h7FFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_OBSERVE, 48'd3200000, c);
    send_item(CMD_TICK, 48'd3200001, c);
    drain();
    set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(CMD_OBSERVE, 48'd3300000, c);
    for (int i = 0; i < COORD_COUNT; i++) c[i] = coord_t'(i * 1000 + 1);
    send_item(CMD_OBSERVE, 48'd3300010, c);
    send_item(CMD_TICK, 48'd3300011, c);
    drain();
    set_all(32'd512, 32'd0, 32'hFFFF, 32'd0, 32'd0, 32'd0);
    send_item(CMD_OBSERVE, 48'd3400000, c);
    drain();

    for (int i = 0; i < COORD_COUNT; i++) base[i] = coord_t'($urandom_range(4000));
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_all(5120, 256, 256, 128, 1000000, 500000);
        1: set_all(2000, 30, 900, 200, 100000, 40000);
        2: set_all($urandom_range(8000), $urandom, $urandom, $urandom, $urandom_range(200000),
                   $urandom_range(100000));
        3: set_all(32'h7FFFFF, 0, 32'hFFFF, 32'hFFFF, 0, 32'hFFFF_FFFF);
        4: set_all(0, 32'hFFFF, 0, 0, 32'hFFFF_FFFF, 0);
        default: set_all(8000, 64, 512, 96, 300000, 80000);
      endcase
      calm = (ph == 1);
      for (int n = 0; n < 200; n++)
        send_rand_item((n % 50 < 45) ? 400 : 6000, $urandom_range(99) < 5);
      drain();
    end
    calm = 1'b0;

    $display("covered %0d results, %0d track restarts, %0d converged reports", results,
             restarts, converged);
    $display("six register settings including extremes, with random stalls on both sides");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
